// ----- rtl/ct_pkg.sv -----
// ----------------------------------------------------------------------------
// ct_pkg: shared types, constants and key helpers
// Sizes, command and result records and the key decode functions used by the
// front, the command queue and the back of the columnar transposition block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ct_pkg;

  localparam int MAX_CHARS   = 64;
  localparam int KEY_MAX     = 12;
  localparam int QUEUE_DEPTH = 4;

  localparam int BYTE_W    = 8;
  localparam int KLEN_W    = 4;
  localparam int RNDS_W    = 4;
  localparam int RANK_W    = 5;
  localparam int RANKS_W   = 60;
  localparam int CFG_W     = 60;
  localparam int CFG_IDX_W = 2;
  localparam int ERR_W     = 2;

  localparam int ADDR_W = $clog2(MAX_CHARS);
  localparam int CNT_W  = $clog2(MAX_CHARS + KEY_MAX + 1);
  localparam int COL_W  = $clog2(KEY_MAX);
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_RANKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_BYTE   = 2'd3;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_KEY      = 2'd2
  } err_t;

  typedef struct packed {
    logic [KLEN_W-1:0]  key_length;
    logic [RANKS_W-1:0] key_ranks;
    logic [RNDS_W-1:0]  rounds;
    logic [BYTE_W-1:0]  pad_byte;
  } cfg_t;

  typedef logic [KEY_MAX-1:0][COL_W-1:0] order_t;

  // One classified input byte on its way to the back.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              store;
    logic [ADDR_W-1:0] addr;
    logic              last;
    logic [CNT_W-1:0]  count;
    err_t              err;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    err_t              err;
  } res_t;

  // True when the first klen ranks are a permutation of 1..klen.
  function automatic logic key_valid(input logic [KLEN_W-1:0]  klen,
                                     input logic [RANKS_W-1:0] ranks);
    logic [KEY_MAX:0]  seen;
    logic [KEY_MAX:0]  want;
    logic              ok;
    logic [RANK_W-1:0] r;
    seen = '0;
    want = '0;
    ok   = (klen != '0) && (int'(klen) <= KEY_MAX);
    for (int j = 0; j < KEY_MAX; j++) begin
      r = ranks[RANK_W*j +: RANK_W];
      if (j < int'(klen)) begin
        if (r == '0 || r > RANK_W'(klen)) begin
          ok = 1'b0;
        end
        seen = seen | ((KEY_MAX+1)'(1) << r);
        want = want | ((KEY_MAX+1)'(1) << (j + 1));
      end
    end
    return ok && (seen == want);
  endfunction

  // Column read out at step i is the column whose rank is i+1.
  function automatic order_t key_order(input logic [KLEN_W-1:0]  klen,
                                       input logic [RANKS_W-1:0] ranks);
    order_t            ord;
    logic [RANK_W-1:0] r;
    ord = '0;
    for (int j = 0; j < KEY_MAX; j++) begin
      r = ranks[RANK_W*j +: RANK_W];
      for (int i = 0; i < KEY_MAX; i++) begin
        if (j < int'(klen) && r == RANK_W'(i + 1)) begin
          ord[i] = COL_W'(j);
        end
      end
    end
    return ord;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ct_front.sv -----
// ----------------------------------------------------------------------------
// ct_front: configuration registers and input classification
// Holds the key registers, counts message bytes and tags each byte with its
// buffer slot, the message length and the error class on the last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ct_front import ct_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [BYTE_W-1:0]    plain_byte,
  input  wire logic                 last_in,
  output logic                      cmd_valid,
  input  wire logic                 cmd_ready,
  output cmd_t                      cmd,
  output cfg_t                      cfg
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_length <= KLEN_W'(1);
      cfg.key_ranks  <= RANKS_W'(1);
      cfg.rounds     <= RNDS_W'(1);
      cfg.pad_byte   <= BYTE_W'(88);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KEY_LENGTH: cfg.key_length <= cfg_data[KLEN_W-1:0];
        REG_KEY_RANKS:  cfg.key_ranks  <= cfg_data[RANKS_W-1:0];
        REG_ROUNDS:     cfg.rounds     <= cfg_data[RNDS_W-1:0];
        REG_PAD_BYTE:   cfg.pad_byte   <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && in_ready;

  // Saturate one past the buffer so an overlong message stays flagged.
  assign count_next = (count <= CNT_W'(MAX_CHARS)) ? CNT_W'(count + 1'b1) : count;

  always_comb begin
    cmd.data  = plain_byte;
    cmd.store = count < CNT_W'(MAX_CHARS);
    cmd.addr  = count[ADDR_W-1:0];
    cmd.last  = last_in;
    cmd.count = count_next;
    if (!key_valid(cfg.key_length, cfg.key_ranks)) begin
      cmd.err = ERR_KEY;
    end else if (count_next > CNT_W'(MAX_CHARS)) begin
      cmd.err = ERR_OVERFLOW;
    end else begin
      cmd.err = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= last_in ? '0 : count_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ct_queue.sv -----
// ----------------------------------------------------------------------------
// ct_queue: command queue between front and back
// Small first-in first-out store of classified bytes so the input side keeps
// loading while the back is busy with a message.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ct_queue import ct_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              push;
  logic              pop;

  assign push_ready = fill != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        fill <= (QPTR_W+1)'(fill + 1'b1);
      end else if (pop && !push) begin
        fill <= (QPTR_W+1)'(fill - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ct_back.sv -----
// ----------------------------------------------------------------------------
// ct_back: buffer, padding, transposition passes and output
// Stores message bytes into bank A, pads the last row, runs the column passes
// between two banks in ping-pong fashion and streams the result out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ct_back import ct_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire cmd_t               cmd,
  input  wire cfg_t               cfg,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [BYTE_W-1:0]       cipher_byte,
  output logic                    last_out,
  output logic [ERR_W-1:0]        error
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SIZE  = 7'b0000010,
    S_PAD   = 7'b0000100,
    S_PASS  = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_ERR   = 7'b1000000
  } state_t;

  state_t            state;
  logic [BYTE_W-1:0] bank_a [MAX_CHARS];
  logic [BYTE_W-1:0] bank_b [MAX_CHARS];
  logic [BYTE_W-1:0] rd_a;
  logic [BYTE_W-1:0] rd_b;

  logic [KLEN_W-1:0] klen;
  logic [RNDS_W-1:0] rnd_total;
  logic [RNDS_W-1:0] rnd_cnt;
  logic [BYTE_W-1:0] pad;
  order_t            order;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  padded;
  logic [CNT_W-1:0]  rows;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  row;
  logic [CNT_W-1:0]  base;
  logic [COL_W-1:0]  col;
  logic              src_b;
  err_t              err_code;

  logic              pw_valid;
  logic [ADDR_W-1:0] pw_addr;
  logic              pw_to_b;
  logic              em_pend;
  logic              em_last;

  logic              a_we;
  logic [ADDR_W-1:0] a_waddr;
  logic [BYTE_W-1:0] a_wdata;
  logic [CNT_W-1:0]  rd_sum;
  logic [ADDR_W-1:0] rd_addr;

  res_t              slot0;
  res_t              slot1;
  logic [1:0]        occ;
  logic [1:0]        held;
  logic              pop;
  logic              push;
  logic              credit;
  logic              issue;
  logic              err_push;
  res_t              push_res;

  assign cmd_ready = state == S_IDLE;

  // Bank writes: input stores, padding, and pass results landing in A.
  always_comb begin
    a_we    = 1'b0;
    a_waddr = cmd.addr;
    a_wdata = cmd.data;
    if (state == S_IDLE) begin
      a_we = cmd_valid && cmd.store;
    end else if (state == S_PAD) begin
      a_we    = idx < padded;
      a_waddr = idx[ADDR_W-1:0];
      a_wdata = pad;
    end else if (pw_valid && !pw_to_b) begin
      a_we    = 1'b1;
      a_waddr = pw_addr;
      a_wdata = rd_b;
    end
  end

  assign rd_sum = CNT_W'(base + CNT_W'(order[col]));

  always_comb begin
    if (state == S_PASS) begin
      rd_addr = rd_sum[ADDR_W-1:0];
    end else begin
      rd_addr = idx[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      bank_a[a_waddr] <= a_wdata;
    end
    rd_a <= bank_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pw_valid && pw_to_b) begin
      bank_b[pw_addr] <= rd_a;
    end
    rd_b <= bank_b[rd_addr];
  end

  // Output queue credit counts held entries plus reads still in flight.
  assign pop      = out_valid && out_ready;
  assign held     = 2'(occ + {1'b0, em_pend});
  assign credit   = (held < 2'd2) || pop;
  assign issue    = (state == S_EMIT) && credit;
  assign err_push = (state == S_ERR) && credit;
  assign push     = em_pend || err_push;

  always_comb begin
    if (em_pend) begin
      push_res.data = src_b ? rd_b : rd_a;
      push_res.last = em_last;
      push_res.err  = ERR_NONE;
    end else begin
      push_res.data = '0;
      push_res.last = 1'b1;
      push_res.err  = err_code;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && occ == 2'd2) begin
      slot0 <= slot1;
    end
    if (push) begin
      if (occ == 2'd0 || (occ == 2'd1 && pop)) begin
        slot0 <= push_res;
      end else begin
        slot1 <= push_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= 2'(occ + {1'b0, push} - {1'b0, pop});
    end
  end

  assign out_valid   = occ != 2'd0;
  assign cipher_byte = slot0.data;
  assign last_out    = slot0.last;
  assign error       = slot0.err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pw_valid <= 1'b0;
      em_pend  <= 1'b0;
    end else begin
      pw_valid <= 1'b0;
      em_pend  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd.last) begin
            klen      <= cfg.key_length;
            rnd_total <= cfg.rounds;
            pad       <= cfg.pad_byte;
            order     <= key_order(cfg.key_length, cfg.key_ranks);
            count     <= cmd.count;
            padded    <= CNT_W'(cfg.key_length);
            rows      <= CNT_W'(1);
            rnd_cnt   <= '0;
            src_b     <= 1'b0;
            err_code  <= cmd.err;
            state     <= (cmd.err != ERR_NONE) ? S_ERR : S_SIZE;
          end
        end
        S_SIZE: begin
          // Step whole rows until the message fits.
          if (padded >= count) begin
            idx <= count;
            if (padded > CNT_W'(MAX_CHARS)) begin
              err_code <= ERR_OVERFLOW;
              state    <= S_ERR;
            end else begin
              state <= S_PAD;
            end
          end else begin
            padded <= CNT_W'(padded + CNT_W'(klen));
            rows   <= CNT_W'(rows + 1'b1);
          end
        end
        S_PAD: begin
          if (idx < padded) begin
            idx <= CNT_W'(idx + 1'b1);
          end else begin
            idx  <= '0;
            row  <= '0;
            col  <= '0;
            base <= '0;
            state <= (rnd_total == '0) ? S_EMIT : S_PASS;
          end
        end
        S_PASS: begin
          pw_valid <= 1'b1;
          pw_addr  <= idx[ADDR_W-1:0];
          pw_to_b  <= !src_b;
          idx      <= CNT_W'(idx + 1'b1);
          if (row == CNT_W'(rows - 1'b1)) begin
            row  <= '0;
            base <= '0;
            if (col == COL_W'(klen - KLEN_W'(1))) begin
              state <= S_DRAIN;
            end else begin
              col <= COL_W'(col + 1'b1);
            end
          end else begin
            row  <= CNT_W'(row + 1'b1);
            base <= CNT_W'(base + CNT_W'(klen));
          end
        end
        S_DRAIN: begin
          // Last pass write lands this cycle; swap banks behind it.
          src_b   <= !src_b;
          rnd_cnt <= RNDS_W'(rnd_cnt + 1'b1);
          idx     <= '0;
          row     <= '0;
          col     <= '0;
          base    <= '0;
          state   <= (RNDS_W'(rnd_cnt + 1'b1) == rnd_total) ? S_EMIT : S_PASS;
        end
        S_EMIT: begin
          if (issue) begin
            em_pend <= 1'b1;
            em_last <= idx == CNT_W'(padded - 1'b1);
            idx     <= CNT_W'(idx + 1'b1);
            if (idx == CNT_W'(padded - 1'b1)) begin
              state <= S_IDLE;
            end
          end
        end
        S_ERR: begin
          if (err_push) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/columnar_transposition.sv -----
// ----------------------------------------------------------------------------
// columnar_transposition: columnar transposition cipher engine
// Buffers a message, pads it to whole rows and reads it out column by column
// in key rank order, repeated for the configured number of rounds.
// ----------------------------------------------------------------------------
//
//   channel   signals                              transfer when
//   -------   ----------------------------------   -----------------------
//   config    cfg_wr_en, cfg_index, cfg_data       cfg_wr_en high
//   input     plain_byte, last_in                  in_valid && in_ready
//   output    cipher_byte, last_out, error         out_valid && out_ready
//
// Input bytes load one per cycle through a four-entry command queue.
// After the last byte the back sizes and pads the message, then runs the
// configured rounds of column passes through the two buffer banks, then
// streams the padded bytes at one per cycle. A key or length error gives
// one result, marked last, after the last byte.
// The input stalls only once the queue is full behind a busy back end; output
// stalls hold the back in its output phase. Reset is synchronous; it clears
// control state and sets the key registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module columnar_transposition import ct_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [BYTE_W-1:0]    plain_byte,
  input  wire logic                 last_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [BYTE_W-1:0]         cipher_byte,
  output logic                      last_out,
  output logic [ERR_W-1:0]          error
);

  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;
  logic qb_valid;
  logic qb_ready;
  cmd_t qb_cmd;
  cfg_t cfg;

  ct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .plain_byte (plain_byte),
    .last_in    (last_in),
    .cmd_valid  (fq_valid),
    .cmd_ready  (fq_ready),
    .cmd        (fq_cmd),
    .cfg        (cfg)
  );

  ct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  ct_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (qb_valid),
    .cmd_ready   (qb_ready),
    .cmd         (qb_cmd),
    .cfg         (cfg),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cipher_byte (cipher_byte),
    .last_out    (last_out),
    .error       (error)
  );

endmodule

`default_nettype wire
